/* rtl/plr_pkg.sv */
`timescale 1ns / 1ps

package plr_pkg;

   // defaults for the top level parameters
   localparam int MAX_PER_SEGMENT_DEF = 63;
   localparam int COORD_BITS_DEF      = 10;

   // fixed field widths of the stream words
   localparam int POINT_W   = 10;
   localparam int SAMPLE_W  = 18;
   localparam int FRAC_BITS = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // rsp_tuser bit positions
   localparam int USER_PATH_END = 0;
   localparam int USER_CLIPPED  = 1;

   // register map
   localparam int  CSR_ADDR_W = 3;
   localparam int  CSR_DATA_W = 32;
   localparam logic CSR_IDX_SAMPLE_INTERVAL = 1'b0;
   localparam logic [7:0] SAMPLE_INTERVAL_RESET = 8'd5;

endpackage

/* rtl/polyline_uniform_resampler.sv */
`timescale 1ns / 1ps

// polyline uniform resampler: keypoints come in one word at a time on req_*, and for each
// segment from the previous keypoint the block sends floor(length/sample_interval) samples
// (at most MAX_PER_SEGMENT, with clipped set when the count saturates) on rsp_* in unsigned
// Q10.8, the quotient of each step truncated toward zero; a keypoint with req_tlast closes
// the path, is sent itself with path_end set, and clears the stored point. The block works
// on one keypoint at a time and drops req_tready while busy. A keypoint with a segment goes
// through one shared multiplier for the squared length and the count search, then one
// shift-subtract divider run per axis, then one sample per cycle while rsp_tready does not
// stall the output. sample_interval is written through the apb port at byte address 0;
// the user must write it only while the block is idle, which the block itself does not
// enforce; zero acts as one.
module polyline_uniform_resampler #(
   parameter int MAX_PER_SEGMENT = plr_pkg::MAX_PER_SEGMENT_DEF,
   parameter int COORD_BITS      = plr_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input keypoint stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [plr_pkg::REQ_DATA_W-1:0] req_tdata,  // point_x[9:0], point_y[19:10], zero pad
   input  logic                           req_tlast,  // final_point
   // sample stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [plr_pkg::RSP_DATA_W-1:0] rsp_tdata,  // sample_x[17:0], sample_y[35:18], pad
   output logic                           rsp_tlast,  // last_of_run
   output logic [plr_pkg::RSP_USER_W-1:0] rsp_tuser,  // path_end[0], clipped[1]
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [plr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [plr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [plr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int CW    = COORD_BITS;
   localparam int NUM_W = $clog2(MAX_PER_SEGMENT + 2);
   localparam int T_W   = $clog2((MAX_PER_SEGMENT + 1) * 255 + 1);
   localparam int MW    = (CW > T_W) ? CW : T_W;
   localparam int PW    = 2 * MW;
   localparam int CMP_W = PW + 1;
   localparam int L_W   = 2 * CW + 1;
   localparam int DW    = CW + plr_pkg::FRAC_BITS;
   localparam int PTW   = plr_pkg::POINT_W;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LENX   = 8'b0000_0010,
      ST_LENY   = 8'b0000_0100,
      ST_SEARCH = 8'b0000_1000,
      ST_DIVX   = 8'b0001_0000,
      ST_DIVY   = 8'b0010_0000,
      ST_EMIT   = 8'b0100_0000,
      ST_FINAL  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // config register
   logic [7:0]       interval_ff, interval_in;
   logic [T_W-1:0]   step_iv;

   // path state
   logic [CW-1:0]    prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic             have_prev_ff, have_prev_in;

   // per keypoint working registers
   logic [CW-1:0]    cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic             fin_ff, fin_in;
   logic [CW-1:0]    mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic             neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [L_W-1:0]   len2_ff, len2_in;
   logic [T_W-1:0]   t_ff, t_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             clip_ff, clip_in;
   logic [NUM_W-1:0] j_ff, j_in;
   logic [DW-1:0]    quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [NUM_W-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DW-1:0]    acc_qx_ff, acc_qx_in, acc_qy_ff, acc_qy_in;
   logic [NUM_W-1:0] acc_rx_ff, acc_rx_in, acc_ry_ff, acc_ry_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [plr_pkg::SAMPLE_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_clip_ff, rsp_clip_in;

   // shared multiplier
   logic [MW-1:0]    mul_a;
   logic [PW-1:0]    prod;
   logic             too_far;

   // divider hookup
   logic             div_start;
   logic [DW-1:0]    div_dividend;
   logic [NUM_W-1:0] div_divisor;
   logic             div_done;
   logic [DW-1:0]    div_quo;
   logic [NUM_W-1:0] div_rem;

   // misc
   logic             req_fire;
   logic             csr_write;
   logic             out_free;
   logic [CW-1:0]    in_x, in_y;
   logic [NUM_W-1:0] num_sel;
   logic             search_done;
   logic             last_sample;
   logic [NUM_W:0]   rx_sum, ry_sum;
   logic             rx_wrap, ry_wrap;
   logic [DW-1:0]    base_x, base_y, samp_x, samp_y;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign in_x = CW'(req_tdata[PTW-1:0]);
   assign in_y = CW'(req_tdata[2*PTW-1:PTW]);

   // zero spacing behaves as one pixel
   assign step_iv = (interval_ff == 8'd0) ? T_W'(1) : T_W'(interval_ff);

   // squares of the deltas first, then (n+1)*interval squared during the search
   always_comb begin
      unique case (state_ff)
         ST_LENX: mul_a = MW'(mag_x_ff);
         ST_LENY: mul_a = MW'(mag_y_ff);
         default: mul_a = MW'(t_ff);
      endcase
   end
   assign prod    = PW'(mul_a) * PW'(mul_a);
   assign too_far = CMP_W'(prod) > CMP_W'(len2_ff);

   // the search stops on the first too-long multiple or once the count saturates
   assign search_done = too_far || (n_ff == NUM_W'(MAX_PER_SEGMENT));
   assign num_sel     = too_far ? n_ff : NUM_W'(MAX_PER_SEGMENT);

   // start x division leaving the search, y division when x is back
   assign div_start    = ((state_ff == ST_SEARCH) && search_done && (num_sel != '0))
                         || ((state_ff == ST_DIVX) && div_done);
   assign div_dividend = (state_ff == ST_SEARCH) ? {mag_x_ff, plr_pkg::FRAC_BITS'(0)}
                                                 : {mag_y_ff, plr_pkg::FRAC_BITS'(0)};
   assign div_divisor  = (state_ff == ST_SEARCH) ? num_sel : num_ff;

   plr_div #(
      .DW (DW),
      .NW (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // running j*|d|*256/num as quotient plus remainder, one carry check per sample
   assign rx_sum  = (NUM_W+1)'(acc_rx_ff) + (NUM_W+1)'(rem_x_ff);
   assign ry_sum  = (NUM_W+1)'(acc_ry_ff) + (NUM_W+1)'(rem_y_ff);
   assign rx_wrap = rx_sum >= (NUM_W+1)'(num_ff);
   assign ry_wrap = ry_sum >= (NUM_W+1)'(num_ff);

   assign base_x = {prev_x_ff, plr_pkg::FRAC_BITS'(0)};
   assign base_y = {prev_y_ff, plr_pkg::FRAC_BITS'(0)};
   assign samp_x = neg_x_ff ? (base_x - acc_qx_ff) : (base_x + acc_qx_ff);
   assign samp_y = neg_y_ff ? (base_y - acc_qy_ff) : (base_y + acc_qy_ff);

   assign last_sample = ((NUM_W+1)'(j_ff) + (NUM_W+1)'(1)) == (NUM_W+1)'(num_ff);

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      fin_in       = fin_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      len2_in      = len2_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      num_in       = num_ff;
      clip_in      = clip_ff;
      j_in         = j_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      acc_qx_in    = acc_qx_ff;
      acc_qy_in    = acc_qy_ff;
      acc_rx_in    = acc_rx_ff;
      acc_ry_in    = acc_ry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_clip_in  = rsp_clip_ff;

      if (csr_write && (paddr[2] == plr_pkg::CSR_IDX_SAMPLE_INTERVAL)) begin
         interval_in = pwdata[7:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_x_in = in_x;
               cur_y_in = in_y;
               fin_in   = req_tlast;
               neg_x_in = in_x < prev_x_ff;
               neg_y_in = in_y < prev_y_ff;
               mag_x_in = (in_x < prev_x_ff) ? (prev_x_ff - in_x) : (in_x - prev_x_ff);
               mag_y_in = (in_y < prev_y_ff) ? (prev_y_ff - in_y) : (in_y - prev_y_ff);
               if (have_prev_ff) begin
                  state_in = ST_LENX;
               end else if (req_tlast) begin
                  state_in = ST_FINAL;
               end else begin
                  // first point of a path: just remember it
                  prev_x_in    = in_x;
                  prev_y_in    = in_y;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_LENX: begin
            len2_in  = L_W'(prod);
            state_in = ST_LENY;
         end
         ST_LENY: begin
            len2_in  = len2_ff + L_W'(prod);
            t_in     = step_iv;
            n_in     = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_done) begin
               num_in  = num_sel;
               clip_in = !too_far;
               if (num_sel != '0) begin
                  state_in = ST_DIVX;
               end else if (fin_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  // segment shorter than one spacing
                  prev_x_in    = cur_x_ff;
                  prev_y_in    = cur_y_ff;
                  have_prev_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               n_in = n_ff + NUM_W'(1);
               t_in = t_ff + step_iv;
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               quo_x_in = div_quo;
               rem_x_in = div_rem;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               quo_y_in  = div_quo;
               rem_y_in  = div_rem;
               acc_qx_in = '0;
               acc_qy_in = '0;
               acc_rx_in = '0;
               acc_ry_in = '0;
               j_in      = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = plr_pkg::SAMPLE_W'(samp_x);
               rsp_y_in     = plr_pkg::SAMPLE_W'(samp_y);
               rsp_last_in  = last_sample && !fin_ff;
               rsp_end_in   = 1'b0;
               rsp_clip_in  = clip_ff;
               acc_qx_in    = acc_qx_ff + quo_x_ff + DW'(rx_wrap);
               acc_qy_in    = acc_qy_ff + quo_y_ff + DW'(ry_wrap);
               acc_rx_in    = rx_wrap ? NUM_W'(rx_sum - (NUM_W+1)'(num_ff)) : NUM_W'(rx_sum);
               acc_ry_in    = ry_wrap ? NUM_W'(ry_sum - (NUM_W+1)'(num_ff)) : NUM_W'(ry_sum);
               j_in         = j_ff + NUM_W'(1);
               if (last_sample) begin
                  if (fin_ff) begin
                     state_in = ST_FINAL;
                  end else begin
                     prev_x_in    = cur_x_ff;
                     prev_y_in    = cur_y_ff;
                     have_prev_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            end
         end
         ST_FINAL: begin
            // closing keypoint goes out as is, then the path is forgotten
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = plr_pkg::SAMPLE_W'({cur_x_ff, plr_pkg::FRAC_BITS'(0)});
               rsp_y_in     = plr_pkg::SAMPLE_W'({cur_y_ff, plr_pkg::FRAC_BITS'(0)});
               rsp_last_in  = 1'b1;
               rsp_end_in   = 1'b1;
               rsp_clip_in  = 1'b0;
               prev_x_in    = '0;
               prev_y_in    = '0;
               have_prev_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= plr_pkg::SAMPLE_INTERVAL_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      fin_ff      <= fin_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      len2_ff     <= len2_in;
      t_ff        <= t_in;
      n_ff        <= n_in;
      num_ff      <= num_in;
      clip_ff     <= clip_in;
      j_ff        <= j_in;
      quo_x_ff    <= quo_x_in;
      quo_y_ff    <= quo_y_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      acc_qx_ff   <= acc_qx_in;
      acc_qy_ff   <= acc_qy_in;
      acc_rx_ff   <= acc_rx_in;
      acc_ry_ff   <= acc_ry_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   // output word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = plr_pkg::RSP_DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_clip_ff, rsp_end_ff};

   // register readback
   assign prdata = (paddr[2] == plr_pkg::CSR_IDX_SAMPLE_INTERVAL)
                   ? plr_pkg::CSR_DATA_W'(interval_ff) : '0;

endmodule

/* rtl/plr_div.sv */
`timescale 1ns / 1ps

module plr_div #(
   parameter int DW = 18,
   parameter int NW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [NW-1:0] remainder
);

   localparam int CNT_W = $clog2(DW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    dvs_ff, dvs_in;

   logic [NW:0]      shifted;
   logic             fits;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? NW'(shifted - {1'b0, dvs_ff}) : NW'(shifted);
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/plr_checker.sv */
`timescale 1ns / 1ps

module plr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [plr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic [plr_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // nothing waits on the output right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled rsp word changed");

   // the closing keypoint always ends its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[plr_pkg::USER_PATH_END] |-> rsp_tlast)
      else $error("path_end without last_of_run");

   // the closing keypoint is never a clipped segment sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[plr_pkg::USER_PATH_END] |-> !rsp_tuser[plr_pkg::USER_CLIPPED])
      else $error("path_end word marked clipped");

endmodule

bind polyline_uniform_resampler plr_checker u_plr_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int POINT_W       = plr_pkg::POINT_W;
   localparam int SAMPLE_W      = plr_pkg::SAMPLE_W;
   localparam int REQ_DATA_W    = plr_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W    = plr_pkg::RSP_DATA_W;
   localparam int RSP_USER_W    = plr_pkg::RSP_USER_W;
   localparam int CSR_ADDR_W    = plr_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W    = plr_pkg::CSR_DATA_W;
   localparam int USER_PATH_END = plr_pkg::USER_PATH_END;
   localparam int USER_CLIPPED  = plr_pkg::USER_CLIPPED;

   localparam int COORD_MAX    = (1 << POINT_W) - 1;
   localparam int SEG_MAX      = plr_pkg::MAX_PER_SEGMENT_DEF;
   localparam int SETTLE       = 300;        // longer than a clipped segment takes
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int HOLD_CYCLES  = 500;        // long receiver stall
   localparam logic [CSR_ADDR_W-1:0] SPACING_ADDR =
      CSR_ADDR_W'(4 * int'(plr_pkg::CSR_IDX_SAMPLE_INTERVAL));

   // one keypoint as offered on req_*
   typedef struct {
      logic [POINT_W-1:0] x;
      logic [POINT_W-1:0] y;
      logic               fin;
   } point_type;

   // one sample as seen on rsp_*
   typedef struct packed {
      logic [SAMPLE_W-1:0] sx;
      logic [SAMPLE_W-1:0] sy;
      logic                run_last;
      logic                path_end;
      logic                clipped;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // point_x[9:0], point_y[19:10], zero pad
   logic                  req_tlast = 1'b0; // final_point
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // sample_x[17:0], sample_y[35:18], pad
   logic                  rsp_tlast;        // last_of_run
   logic [RSP_USER_W-1:0] rsp_tuser;        // path_end[0], clipped[1]
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   point_type  keypoint_queue[$];   // words still to offer
   sample_type sample_queue[$];     // samples still owed by the block
   int      error_count = 0;
   int      cycle_count = 0;
   bit      calm = 1'b0;         // no random idling on either side while set

   // predictor copy of the block state and register
   logic [POINT_W-1:0] held_x = '0;
   logic [POINT_W-1:0] held_y = '0;
   bit                 held_valid = 1'b0;
   logic [7:0]         spacing_cfg = plr_pkg::SAMPLE_INTERVAL_RESET;

   polyline_uniform_resampler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // expected samples for one accepted keypoint, then the state update
   function automatic void resample_keypoint(input logic [POINT_W-1:0] qx,
                                             input logic [POINT_W-1:0] qy,
                                             input logic fin);
      int      dx, dy, len2, iv, num, j, step;
      bit      clip;
      sample_type s;
      clip = 1'b0;
      if (held_valid) begin
         dx   = int'(qx) - int'(held_x);
         dy   = int'(qy) - int'(held_y);
         len2 = dx * dx + dy * dy;
         iv   = (spacing_cfg == 8'd0) ? 1 : int'(spacing_cfg);
         // count search stops one past the cap so saturation is visible
         num  = 0;
         step = iv;
         while (num <= SEG_MAX && step * step <= len2) begin
            num++;
            step = (num + 1) * iv;
         end
         if (num > SEG_MAX) begin
            num  = SEG_MAX;
            clip = 1'b1;
         end
         for (j = 0; j < num; j++) begin
            // signed division truncates toward zero
            s.sx       = SAMPLE_W'(int'(held_x) * 256 + (j * dx * 256) / num);
            s.sy       = SAMPLE_W'(int'(held_y) * 256 + (j * dy * 256) / num);
            s.run_last = !fin && (j == num - 1);
            s.path_end = 1'b0;
            s.clipped  = clip;
            sample_queue = {sample_queue, s};
         end
      end
      if (fin) begin
         // closing keypoint itself, then forget the path
         s.sx       = SAMPLE_W'({qx, 8'd0});
         s.sy       = SAMPLE_W'({qy, 8'd0});
         s.run_last = 1'b1;
         s.path_end = 1'b1;
         s.clipped  = 1'b0;
         sample_queue = {sample_queue, s};
         held_x     = '0;
         held_y     = '0;
         held_valid = 1'b0;
      end else begin
         held_x     = qx;
         held_y     = qy;
         held_valid = 1'b1;
      end
   endfunction

   // keypoint driver: holds a word until it is taken, idles at random between words
   point_type next_point;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            resample_keypoint(req_tdata[POINT_W-1:0], req_tdata[2*POINT_W-1:POINT_W],
                              req_tlast);
         if (!req_tvalid || req_tready) begin
            if (keypoint_queue.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
               next_point = keypoint_queue.pop_front();
               req_tdata  <= {{(REQ_DATA_W - 2 * POINT_W){1'b0}}, next_point.y, next_point.x};
               req_tlast  <= next_point.fin;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // sample monitor with random back-pressure and occasional long hold-off
   int      rsp_count = 0;
   int      hold_left = 0;
   int      hold_mark = 200;
   sample_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{sx: rsp_tdata[SAMPLE_W-1:0], sy: rsp_tdata[2*SAMPLE_W-1:SAMPLE_W],
                    run_last: rsp_tlast, path_end: rsp_tuser[USER_PATH_END],
                    clipped: rsp_tuser[USER_CLIPPED]};
            rsp_count++;
            if (sample_queue.size() == 0) begin
               error_count++;
               $display("%0t unexpected sample x=%h y=%h last=%b end=%b clip=%b", $time,
                        got.sx, got.sy, got.run_last, got.path_end, got.clipped);
            end else begin
               want = sample_queue.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t sample mismatch: expected x=%h y=%h last=%b end=%b clip=%b",
                           $time, want.sx, want.sy, want.run_last, want.path_end,
                           want.clipped);
                  $display("%0t                  actual   x=%h y=%h last=%b end=%b clip=%b",
                           $time, got.sx, got.sy, got.run_last, got.path_end, got.clipped);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_count >= hold_mark) begin
            // stall the output long enough that the input backs up
            hold_left = HOLD_CYCLES;
            hold_mark = hold_mark + 5000;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 26);
         end
      end
   end

   task automatic queue_point(input int x, input int y, input bit fin);
      point_type p;
      p.x   = POINT_W'(x);
      p.y   = POINT_W'(y);
      p.fin = fin;
      keypoint_queue = {keypoint_queue, p};
   endtask

   // random paths: mostly steps sized to the spacing, some jumps, some tiny moves
   task automatic queue_random_paths(input int n_items, input int iv);
      int left, plen, k, r, mode, nx, ny;
      left = n_items;
      while (left > 0) begin
         plen = $urandom_range(8, 1);
         if (plen > left)
            plen = left;
         nx = $urandom_range(COORD_MAX);
         ny = $urandom_range(COORD_MAX);
         for (k = 0; k < plen; k++) begin
            if (k > 0) begin
               mode = $urandom_range(9);
               if (mode < 2) begin
                  nx = $urandom_range(COORD_MAX);
                  ny = $urandom_range(COORD_MAX);
               end else if (mode < 9) begin
                  r = (mode < 7) ? iv * $urandom_range(70) : iv + 1;
                  if (r > COORD_MAX)
                     r = COORD_MAX;
                  nx = nx + int'($urandom_range(2 * r)) - r;
                  ny = ny + int'($urandom_range(2 * r)) - r;
                  nx = (nx < 0) ? 0 : (nx > COORD_MAX) ? COORD_MAX : nx;
                  ny = (ny < 0) ? 0 : (ny > COORD_MAX) ? COORD_MAX : ny;
               end
               // mode 9 repeats the point: zero-length segment
            end
            // most paths close, a few are left open into the next one
            queue_point(nx, ny, (k == plen - 1) && ($urandom_range(9) != 0));
         end
         left -= plen;
      end
   endtask

   // wait until every word is taken and every sample seen, then let the block go idle
   task automatic wait_drained();
      do
         @(posedge clock);
      while (keypoint_queue.size() != 0 || req_tvalid || sample_queue.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write then read-back, only while the block is idle
   task automatic write_spacing(input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SPACING_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      spacing_cfg = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== CSR_DATA_W'(value)) begin
         error_count++;
         $display("%0t sample_interval read-back: expected %h actual %h", $time,
                  CSR_DATA_W'(value), prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   logic [7:0] spacing_plan[7];
   int         ph;
   initial begin
      spacing_plan = '{8'd1, 8'd255, 8'd0, 8'd17, 8'($urandom_range(254, 2)), 8'd128, 8'd5};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset spacing of 5
      queue_point(0, 0, 1);                 // lone point that is also the last
      queue_point(COORD_MAX, COORD_MAX, 1);
      queue_point(0, 0, 0);                 // path start emits nothing
      queue_point(COORD_MAX, COORD_MAX, 0); // diagonal, count saturates
      queue_point(COORD_MAX, 0, 0);         // negative step, saturates
      queue_point(COORD_MAX, 0, 0);         // zero length
      queue_point(1020, 2, 0);              // shorter than one spacing
      queue_point(705, 2, 0);               // exactly the cap, not clipped
      queue_point(385, 2, 0);               // one past the cap
      queue_point(385, 7, 0);               // length exactly one spacing
      queue_point(388, 11, 0);
      queue_point(10'h155, 10'h2aa, 0);
      queue_point(10'h2aa, 10'h155, 0);
      queue_point(0, COORD_MAX, 1);         // closing point after a segment
      queue_point(10, 10, 0);
      queue_point(11, 11, 1);               // short segment then close
      queue_point(500, 500, 0);
      queue_point(503, 496, 0);
      queue_point(500, 500, 1);             // single sample then close
      queue_point(600, 600, 0);
      queue_point(583, 600, 0);             // inexact negative quotient
      queue_point(600, 617, 1);
      wait_drained();

      for (ph = 0; ph < 7; ph++) begin
         write_spacing(spacing_plan[ph]);
         @(negedge clock);
         calm = (ph == 3);
         queue_random_paths(55, (spacing_plan[ph] == 8'd0) ? 1 : int'(spacing_plan[ph]));
         wait_drained();
      end

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
